/* rtl/assert_macros.svh */
// Assertion macros used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk_sig, rst_n_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Types and codes of the sorted priority queue.
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int MODE_W = 3;
	localparam int POS_W = 4;
	localparam int STAT_W = 2;
	localparam int OCC_W = 5;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP_MAX = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_MIN = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PEEK = 3'd4;
	localparam logic [MODE_W-1:0] MODE_FIND = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic signed [DATA_W-1:0] item_value;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [STAT_W-1:0] status;
		logic found;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	// broadcast from the queue control to every cell
	typedef struct packed {
		logic push;
		logic remove;
		logic signed [DATA_W-1:0] item;
	} cell_ctrl_t;

endpackage

/* rtl/spq_cell.sv */
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell #(
	parameter int IDX = 0,
	parameter int AW = 5
) (
	input logic clk,
	input spq_pkg::cell_ctrl_t ctrl,
	input logic [AW-1:0] idx,
	input logic [AW-1:0] count,
	input logic left_take,
	input logic [spq_pkg::DATA_W-1:0] left_val,
	input logic [spq_pkg::DATA_W-1:0] right_val,
	output logic take,
	output logic [spq_pkg::DATA_W-1:0] entry,
	output logic [spq_pkg::DATA_W-1:0] read_val,
	output logic match
);
	import spq_pkg::*;

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic [DATA_W-1:0] entry_q;
	logic occupied;
	logic gt;

	// slot state against the broadcast item
	always_comb begin
		occupied = MY_IDX < count;
		gt = $signed(ctrl.item) > $signed(entry_q);
		take = gt || !occupied;
		match = occupied && (entry_q == ctrl.item);
		read_val = (MY_IDX == idx) ? entry_q : '0;
	end

	// insert, shift down on push, shift up on remove
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (left_take) begin
				entry_q <= left_val;
			end else if (take) begin
				entry_q <= ctrl.item;
			end
		end else if (ctrl.remove) begin
			if (MY_IDX >= idx) begin
				entry_q <= right_val;
			end
		end
	end

	assign entry = entry_q;

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// Sorted priority queue: descending chain of cells, one operation per beat.
// A response is registered and appears in the cycle after its request beat is accepted.
// Throughput: one operation per cycle while responses are taken; the count
// register and the cells are updated at the edge that accepts each operation.
// Reset clears the entry count and the response valid; entries are not cleared.
`include "assert_macros.svh"

module sorted_priority_queue_unit #(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input spq_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0] count_q, count_d;
	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;
	logic accept;
	logic [AW-1:0] count_a, pos_a, idx_a;
	logic is_full, cnt_zero, pos_ok;
	cell_ctrl_t ctrl;
	logic [DEPTH-1:0] take, match;
	logic [DEPTH-1:0] left_take;
	logic [DATA_W-1:0] entry [DEPTH];
	logic [DATA_W-1:0] left_val [DEPTH];
	logic [DATA_W-1:0] right_val [DEPTH];
	logic [DATA_W-1:0] read_val [DEPTH];
	logic [DATA_W-1:0] read_or;

	// take a request when the response register is free or draining
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept = req_valid && req_ready;

	// decode the request against the current count
	always_comb begin
		count_a = AW'(count_q);
		pos_a = AW'(req.position);
		is_full = count_q == CW'(DEPTH);
		cnt_zero = count_q == '0;
		pos_ok = pos_a < count_a;
		idx_a = pos_a;
		if (req.mode == MODE_POP_MAX) begin
			idx_a = '0;
		end else if (req.mode == MODE_POP_MIN) begin
			idx_a = count_a - AW'(1);
		end
		ctrl.item = req.item_value;
		ctrl.push = accept && (req.mode == MODE_PUSH) && !is_full;
		ctrl.remove = accept && (
			((req.mode == MODE_POP_MAX || req.mode == MODE_POP_MIN) && !cnt_zero) ||
			((req.mode == MODE_REMOVE) && pos_ok));
	end

	// chain of cells, each wired to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_take[i] = 1'b0;
			assign left_val[i] = req.item_value;
		end else begin : g_body
			assign left_take[i] = take[i-1];
			assign left_val[i] = entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_val[i] = entry[i];
		end else begin : g_mid
			assign right_val[i] = entry[i+1];
		end

		spq_cell #(
			.IDX(i),
			.AW(AW)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.idx(idx_a),
			.count(count_a),
			.left_take(left_take[i]),
			.left_val(left_val[i]),
			.right_val(right_val[i]),
			.take(take[i]),
			.entry(entry[i]),
			.read_val(read_val[i]),
			.match(match[i])
		);
	end

	// gather the addressed entry
	always_comb begin
		read_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			read_or = read_or | read_val[i];
		end
	end

	// build the response and the next count
	always_comb begin
		rsp_d.result_value = '0;
		rsp_d.status = ST_OK;
		rsp_d.found = 1'b0;
		case (req.mode) inside
			MODE_PUSH: begin
				if (is_full) begin
					rsp_d.status = ST_FULL;
				end
			end
			MODE_POP_MAX, MODE_POP_MIN: begin
				if (cnt_zero) begin
					rsp_d.status = ST_RANGE;
				end else begin
					rsp_d.result_value = read_or;
				end
			end
			MODE_REMOVE, MODE_PEEK: begin
				if (!pos_ok) begin
					rsp_d.status = ST_RANGE;
				end else begin
					rsp_d.result_value = read_or;
				end
			end
			MODE_FIND: begin
				rsp_d.found = |match;
			end
			default: begin
			end
		endcase
		count_d = count_q;
		if (ctrl.push) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.remove) begin
			count_d = count_q - CW'(1);
		end
		rsp_d.occupancy = OCC_W'(count_d);
	end

	// hold count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the response beat
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "count exceeds depth")
	`ASSERT_IMPL(a_push_grows, clk, arst_n, ctrl.push, ##1 (count_q == $past(count_q) + CW'(1)), "push")
	`ASSERT_IMPL(a_rsp_after_accept, clk, arst_n, accept, ##1 rsp_valid_q, "accepted beat gave no response")
	`ASSERT_IMPL(a_occ_tracks, clk, arst_n, rsp_valid_q, (rsp_q.occupancy == OCC_W'(count_q)), "occupancy")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the sorted priority queue unit.
module tb;
	import spq_pkg::*;

	localparam int QDEPTH = 16;
	localparam int RAND_PER_PHASE = 360;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PEND_DEPTH = 8;
	localparam int SCRIPT_MAX = 32;

	// mode codes that the block treats as no operation
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	typedef struct {
		req_t op;
		int unsigned reps;
		bit typed;
		rsp_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// shadow copy of the queue contents, largest first
	logic signed [DATA_W-1:0] held_vals [QDEPTH];
	int unsigned held_count = 0;

	// ring of responses still owed by the block
	rsp_t pending_rsp [PEND_DEPTH];
	int unsigned pend_wr = 0;
	int unsigned pend_rd = 0;
	script_row_t script_rows [SCRIPT_MAX];
	int unsigned script_len = 0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 33;
	int unsigned recv_stall_pct = 80;
	bit filling = 1'b1;

	sorted_priority_queue_unit #(.DEPTH(QDEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// pull one entry out and close the gap behind it
	function automatic logic signed [DATA_W-1:0] take_entry(int unsigned idx);
		logic signed [DATA_W-1:0] v;
		v = held_vals[idx];
		for (int unsigned k = idx; k + 1 < held_count; k++)
			held_vals[k] = held_vals[k + 1];
		held_count--;
		return v;
	endfunction

	// apply one operation to the shadow queue and return the response it gives
	function automatic rsp_t sorted_queue_apply(req_t op);
		rsp_t r;
		int unsigned at;
		r = '0;
		r.status = ST_OK;
		case (op.mode)
			MODE_PUSH: begin
				if (held_count >= QDEPTH) begin
					r.status = ST_FULL;
				end else begin
					// equal values stay ahead of the new one
					at = 0;
					while (at < held_count && !(op.item_value > held_vals[at]))
						at++;
					for (int unsigned k = held_count; k > at; k--)
						held_vals[k] = held_vals[k - 1];
					held_vals[at] = op.item_value;
					held_count++;
				end
			end
			MODE_POP_MAX, MODE_POP_MIN: begin
				if (held_count == 0)
					r.status = ST_RANGE;
				else
					r.result_value = take_entry(op.mode == MODE_POP_MAX ? 0 : held_count - 1);
			end
			MODE_REMOVE, MODE_PEEK: begin
				if (op.position >= held_count)
					r.status = ST_RANGE;
				else if (op.mode == MODE_REMOVE)
					r.result_value = take_entry(op.position);
				else
					r.result_value = held_vals[op.position];
			end
			MODE_FIND: begin
				for (int unsigned k = 0; k < held_count; k++)
					if (held_vals[k] == op.item_value)
						r.found = 1'b1;
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(held_count);
		return r;
	endfunction

	// draw one operation, biased toward filling or draining the queue
	function automatic req_t pick_op();
		req_t op;
		int unsigned sel;
		int unsigned vsel;
		op.mode = MODE_PUSH;
		op.item_value = $urandom;
		op.position = $urandom_range(QDEPTH - 1);
		if (held_count == QDEPTH && $urandom_range(3) == 0)
			filling = 1'b0;
		else if (held_count == 0 && $urandom_range(3) == 0)
			filling = 1'b1;
		else if ($urandom_range(59) == 0)
			filling = !filling;
		sel = $urandom_range(99);
		if (sel < (filling ? 55 : 15))
			op.mode = MODE_PUSH;
		else if (sel < (filling ? 62 : 35))
			op.mode = MODE_POP_MAX;
		else if (sel < (filling ? 68 : 55))
			op.mode = MODE_POP_MIN;
		else if (sel < 72)
			op.mode = MODE_REMOVE;
		else if (sel < 85)
			op.mode = MODE_PEEK;
		else if (sel < 97)
			op.mode = MODE_FIND;
		else
			op.mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
		// mix extremes, a small pool of repeats and stored values into the data
		vsel = $urandom_range(9);
		if (vsel == 0)
			op.item_value = 32'h80000000;
		else if (vsel == 1)
			op.item_value = 32'h7FFFFFFF;
		else if (vsel <= 4)
			op.item_value = $urandom_range(6) - 3;
		else if (vsel <= 6 && held_count != 0)
			op.item_value = held_vals[$urandom_range(held_count - 1)];
		if (held_count != 0 && $urandom_range(3) != 0)
			op.position = $urandom_range(held_count - 1);
		return op;
	endfunction

	task automatic add_row(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] value,
			input logic [POS_W-1:0] pos, input int unsigned reps, input bit typed,
			input logic signed [DATA_W-1:0] want_value, input logic [STAT_W-1:0] want_status,
			input logic want_found, input logic [OCC_W-1:0] want_occ);
		script_row_t row;
		row.op.mode = mode;
		row.op.item_value = value;
		row.op.position = pos;
		row.reps = reps;
		row.typed = typed;
		row.want.result_value = want_value;
		row.want.status = want_status;
		row.want.found = want_found;
		row.want.occupancy = want_occ;
		script_rows[script_len] = row;
		script_len++;
	endtask

	task automatic log_fault(input string text);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", text);
	endtask

	// present one beat, wait for it to be taken, then record its response
	task automatic issue_op(input req_t op, input bit typed, input rsp_t typed_rsp);
		rsp_t model_rsp;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= op;
		do @(posedge clk); while (!req_ready);
		model_rsp = sorted_queue_apply(op);
		pending_rsp[pend_wr % PEND_DEPTH] = typed ? typed_rsp : model_rsp;
		pend_wr++;
		@(negedge clk);
	endtask

	// hold the request side until every response is back
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pend_wr != pend_rd)
			@(negedge clk);
	endtask

	// stall the response side at random
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// check each response beat against the oldest pending one
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pend_wr == pend_rd) begin
				log_fault($sformatf("unexpected response: value %0d status %0d found %0d occ %0d",
					rsp.result_value, rsp.status, rsp.found, rsp.occupancy));
			end else begin
				want = pending_rsp[pend_rd % PEND_DEPTH];
				pend_rd++;
				if (rsp.result_value !== want.result_value || rsp.status !== want.status ||
						rsp.found !== want.found || rsp.occupancy !== want.occupancy)
					log_fault($sformatf({"mismatch: value exp %0d got %0d, status exp %0d got %0d,",
						" found exp %0d got %0d, occ exp %0d got %0d"},
						want.result_value, rsp.result_value, want.status, rsp.status,
						want.found, rsp.found, want.occupancy, rsp.occupancy));
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned issued;
		req_t op;
		rsp_t none;
		none = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue, no-op modes, extremes, equal values, range edge, full
		add_row(MODE_POP_MAX, 0, 0, 1, 1, 0, ST_RANGE, 0, 0);
		add_row(MODE_POP_MIN, 0, 0, 1, 1, 0, ST_RANGE, 0, 0);
		add_row(MODE_REMOVE, 0, 0, 1, 1, 0, ST_RANGE, 0, 0);
		add_row(MODE_PEEK, 0, 0, 1, 1, 0, ST_RANGE, 0, 0);
		add_row(MODE_FIND, 0, 0, 1, 1, 0, ST_OK, 0, 0);
		add_row(MODE_SPARE_LO, -1, 15, 1, 1, 0, ST_OK, 0, 0);
		add_row(MODE_SPARE_HI, 32'h7FFFFFFF, 15, 1, 1, 0, ST_OK, 0, 0);
		add_row(MODE_PUSH, 32'h7FFFFFFF, 15, 1, 1, 0, ST_OK, 0, 1);
		add_row(MODE_PUSH, 32'h80000000, 0, 1, 1, 0, ST_OK, 0, 2);
		add_row(MODE_PUSH, 0, 0, 1, 1, 0, ST_OK, 0, 3);
		add_row(MODE_PUSH, 0, 0, 1, 1, 0, ST_OK, 0, 4);
		add_row(MODE_PUSH, -1, 0, 1, 1, 0, ST_OK, 0, 5);
		add_row(MODE_PEEK, 0, 0, 1, 1, 32'h7FFFFFFF, ST_OK, 0, 5);
		add_row(MODE_PEEK, 0, 4, 1, 1, 32'h80000000, ST_OK, 0, 5);
		add_row(MODE_PEEK, 0, 5, 1, 1, 0, ST_RANGE, 0, 5);
		add_row(MODE_FIND, 0, 0, 1, 1, 0, ST_OK, 1, 5);
		add_row(MODE_FIND, 5, 0, 1, 1, 0, ST_OK, 0, 5);
		add_row(MODE_REMOVE, 0, 2, 1, 1, 0, ST_OK, 0, 4);
		add_row(MODE_POP_MIN, 0, 0, 1, 1, 32'h80000000, ST_OK, 0, 3);
		add_row(MODE_POP_MAX, 0, 0, 1, 1, 32'h7FFFFFFF, ST_OK, 0, 2);
		add_row(MODE_PUSH, 5, 0, 14, 0, 0, ST_OK, 0, 0);
		add_row(MODE_PUSH, 100, 0, 1, 1, 0, ST_FULL, 0, 16);
		add_row(MODE_PEEK, 0, 15, 1, 1, -1, ST_OK, 0, 16);
		add_row(MODE_FIND, -1, 0, 1, 1, 0, ST_OK, 1, 16);
		add_row(MODE_REMOVE, 0, 15, 1, 0, 0, ST_OK, 0, 0);

		for (int unsigned i = 0; i < script_len; i++)
			repeat (script_rows[i].reps)
				issue_op(script_rows[i].op, script_rows[i].typed, script_rows[i].want);
		hold_until_drained();

		// random traffic under three idle profiles
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 80 : 0;
			recv_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 33 : 0;
			issued = 0;
			while (issued < RAND_PER_PHASE) begin
				op = pick_op();
				issue_op(op, 0, none);
				if (op.mode <= MODE_FIND)
					issued++;
			end
			hold_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && pend_wr == pend_rd)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
dv/tb.sv
